/* src/rbe_pkg.sv */
// ----------------------------------------------------------------------------
// rbe_pkg: shared types and constants for the ray/box entry point pipeline
// Formats, pipeline sizing and the side-band record that travels with an item.
// ----------------------------------------------------------------------------
package rbe_pkg;

	// Number formats.
	localparam int POS_W    = 32;
	localparam int DIR_FRAC = 16;
	localparam int DIR_W    = DIR_FRAC + 2;
	localparam int DIFF_W   = POS_W + 1;
	localparam int T_W      = POS_W + 2;
	localparam int TS_W     = T_W + 1;
	localparam int TH_W     = T_W + 1 - DIR_FRAC;
	localparam int PH_W     = TH_W + 1 + DIR_W;
	localparam int PL_W     = DIR_FRAC + 1 + DIR_W;
	localparam int SUM_W    = PH_W + 2;

	// Divider sizing: a few quotient bits per stage on a narrow remainder.
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = (T_W + DIV_STEP - 1) / DIV_STEP;
	localparam int Q_W        = DIV_STAGES * DIV_STEP;
	localparam int NUM_W      = DIFF_W + DIR_FRAC;
	localparam int TOP_W      = NUM_W - Q_W;
	localparam int REM_W      = DIR_W;

	// Cycles from the transfer of a ray to its result strobe.
	localparam int LATENCY = DIV_STAGES + 5;

	// Configuration register indexes.
	localparam int CFG_W = 3;
	typedef enum logic [CFG_W-1:0] {
		REG_X_MIN = 3'd0,
		REG_X_MAX = 3'd1,
		REG_Y_MIN = 3'd2,
		REG_Y_MAX = 3'd3,
		REG_Z_MIN = 3'd4,
		REG_Z_MAX = 3'd5
	} reg_idx_t;
	localparam int NUM_REGS = 6;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [DIR_W-1:0] dir_t;
	typedef logic        [DIR_W-1:0] mag_t;
	typedef logic        [DIFF_W-1:0] num_t;
	typedef logic        [T_W-1:0]    tq_t;
	typedef logic signed [TS_W-1:0]   ts_t;

	// Side-band record that runs alongside the division.
	typedef struct packed {
		pos_t [2:0]  pos;
		dir_t [2:0]  dir;
		logic [5:0]  neg;
		logic [2:0]  dzero;
		logic        in_box;
		logic        zmiss;
	} side_t;

endpackage

/* src/rbe_front.sv */
// ----------------------------------------------------------------------------
// rbe_front: first pipeline stage
// Slab differences, magnitudes and signs, the inside test and the zero
// direction check.
// ----------------------------------------------------------------------------
module rbe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  rbe_pkg::pos_t [2:0]            pos,
	input  rbe_pkg::dir_t [2:0]            dir,
	input  rbe_pkg::pos_t [5:0]            bnd,
	output logic                           vld_s1,
	output rbe_pkg::side_t                 side_s1,
	output rbe_pkg::num_t [5:0]            nmag_s1,
	output rbe_pkg::mag_t [2:0]            dmag_s1
);
	import rbe_pkg::*;

	side_t            side_c;
	num_t [5:0]       nmag_c;
	mag_t [2:0]       dmag_c;

	// Per axis: inside test, zero direction miss and the two slab numerators.
	always_comb begin
		logic signed [DIFF_W-1:0] diff;
		pos_t                     lo;
		pos_t                     hi;
		side_c        = '0;
		side_c.pos    = pos;
		side_c.dir    = dir;
		side_c.in_box = 1'b1;
		nmag_c        = '0;
		dmag_c        = '0;
		diff          = '0;
		for (int i = 0; i < 3; i++) begin
			lo = bnd[2*i];
			hi = bnd[2*i+1];
			if (!(pos[i] > lo && pos[i] < hi)) begin
				side_c.in_box = 1'b0;
			end
			side_c.dzero[i] = (dir[i] == '0);
			if (side_c.dzero[i] && (pos[i] < lo || pos[i] > hi)) begin
				side_c.zmiss = 1'b1;
			end
			dmag_c[i] = dir[i][DIR_W-1] ? mag_t'(-dir[i]) : mag_t'(dir[i]);
			for (int e = 0; e < 2; e++) begin
				diff = (e == 0) ? (DIFF_W'(lo) - DIFF_W'(pos[i]))
				                : (DIFF_W'(hi) - DIFF_W'(pos[i]));
				nmag_c[2*i+e]     = diff[DIFF_W-1] ? num_t'(-diff) : num_t'(diff);
				side_c.neg[2*i+e] = diff[DIFF_W-1] ^ dir[i][DIR_W-1];
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c;
		nmag_s1 <= nmag_c;
		dmag_s1 <= dmag_c;
	end

endmodule

/* src/rbe_div.sv */
// ----------------------------------------------------------------------------
// rbe_div: pipelined saturating divider for one slab distance
// Computes min(floor(num * 2^DIR_FRAC / dmag), 2^T_W - 1), a few quotient
// bits per stage on a remainder no wider than the divisor.
// ----------------------------------------------------------------------------
module rbe_div (
	input  logic                 clk,
	input  rbe_pkg::num_t        num,
	input  rbe_pkg::mag_t        dmag,
	output rbe_pkg::tq_t         quot
);
	import rbe_pkg::*;

	logic [REM_W-1:0] rem_s [DIV_STAGES];
	logic [Q_W-1:0]   quo_s [DIV_STAGES];
	logic [Q_W-1:0]   nlo_s [DIV_STAGES];
	mag_t             dm_s  [DIV_STAGES];
	logic             sat_s [DIV_STAGES];

	logic [NUM_W-1:0] n_full;
	logic [TOP_W-1:0] top;
	logic             ovf0;

	// The bits above the quotient range must stay below the divisor,
	// otherwise the quotient is out of range and saturates.
	assign n_full = {num, {DIR_FRAC{1'b0}}};
	assign top    = n_full[NUM_W-1 -: TOP_W];
	assign ovf0   = ({{(REM_W-TOP_W){1'b0}}, top} >= dmag);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
		logic [REM_W-1:0] r_in;
		logic [Q_W-1:0]   q_in;
		logic [Q_W-1:0]   n_in;
		mag_t             d_in;
		logic             s_in;
		logic [REM_W-1:0] r_nx;
		logic [Q_W-1:0]   q_nx;
		logic [Q_W-1:0]   n_nx;

		if (k == 0) begin : g_first
			assign r_in = ovf0 ? '0 : {{(REM_W-TOP_W){1'b0}}, top};
			assign q_in = '0;
			assign n_in = n_full[Q_W-1:0];
			assign d_in = dmag;
			assign s_in = ovf0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = quo_s[k-1];
			assign n_in = nlo_s[k-1];
			assign d_in = dm_s[k-1];
			assign s_in = sat_s[k-1];
		end

		// Restoring division steps for this stage.
		always_comb begin
			logic [REM_W:0] trial;
			r_nx  = r_in;
			q_nx  = q_in;
			n_nx  = n_in;
			trial = '0;
			for (int j = 0; j < DIV_STEP; j++) begin
				trial = {r_nx, n_nx[Q_W-1]};
				n_nx  = {n_nx[Q_W-2:0], 1'b0};
				if (trial >= {1'b0, d_in}) begin
					trial = trial - {1'b0, d_in};
					q_nx  = {q_nx[Q_W-2:0], 1'b1};
				end else begin
					q_nx  = {q_nx[Q_W-2:0], 1'b0};
				end
				r_nx = trial[REM_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= r_nx;
			quo_s[k] <= q_nx;
			nlo_s[k] <= n_nx;
			dm_s[k]  <= d_in;
			sat_s[k] <= s_in;
		end
	end

	// Clamp to the largest distance when the quotient leaves its range.
	assign quot = (sat_s[DIV_STAGES-1] || ((quo_s[DIV_STAGES-1] >> T_W) != '0))
	              ? '1 : quo_s[DIV_STAGES-1][T_W-1:0];

endmodule

/* src/rbe_select.sv */
// ----------------------------------------------------------------------------
// rbe_select: slab distance selection, two pipeline stages
// Signs the distances, orders them per axis, then takes the latest entry
// and earliest exit and decides hit or miss.
// ----------------------------------------------------------------------------
module rbe_select (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld,
	input  rbe_pkg::side_t          side,
	input  rbe_pkg::tq_t [5:0]      quot,
	output logic                    vld_s2,
	output rbe_pkg::side_t          side_s2,
	output logic                    hit_s2,
	output logic                    enter_s2,
	output logic [rbe_pkg::T_W:0]   step_s2
);
	import rbe_pkg::*;

	ts_t [2:0] near_c;
	ts_t [2:0] far_c;
	ts_t [2:0] near_s1;
	ts_t [2:0] far_s1;
	side_t     side_s1;
	logic      vld_s1;

	logic             hit_c;
	logic             enter_c;
	logic [T_W:0]     step_c;

	// Signed distances, ordered into near and far per axis.
	always_comb begin
		ts_t a0;
		ts_t an;
		a0 = '0;
		an = '0;
		for (int i = 0; i < 3; i++) begin
			a0 = side.neg[2*i]   ? -ts_t'({1'b0, quot[2*i]})   : ts_t'({1'b0, quot[2*i]});
			an = side.neg[2*i+1] ? -ts_t'({1'b0, quot[2*i+1]}) : ts_t'({1'b0, quot[2*i+1]});
			near_c[i] = (a0 < an) ? a0 : an;
			far_c[i]  = (a0 < an) ? an : a0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		near_s1 <= near_c;
		far_s1  <= far_c;
		side_s1 <= side;
	end

	// Latest entry, earliest exit over the axes that have a direction.
	always_comb begin
		ts_t amin;
		ts_t amax;
		logic ent;
		amin = {1'b1, {(TS_W-1){1'b0}}};
		amax = {1'b0, {(TS_W-1){1'b1}}};
		for (int i = 0; i < 3; i++) begin
			if (!side_s1.dzero[i]) begin
				if (near_s1[i] > amin) begin
					amin = near_s1[i];
				end
				if (far_s1[i] < amax) begin
					amax = far_s1[i];
				end
			end
		end
		ent     = !side_s1.zmiss && (amin < amax) && (amin > ts_t'(0));
		hit_c   = side_s1.in_box || ent;
		enter_c = !side_s1.in_box && ent;
		step_c  = amin[T_W:0] + 1'b1;
	end

	always_ff @(posedge clk) begin
		side_s2  <= side_s1;
		hit_s2   <= hit_c;
		enter_s2 <= enter_c;
		step_s2  <= step_c;
	end

endmodule

/* src/rbe_entry.sv */
// ----------------------------------------------------------------------------
// rbe_entry: entry point arithmetic, two pipeline stages
// Multiplies the entry distance by each direction component, then adds,
// rounds down and saturates into the result register.
// ----------------------------------------------------------------------------
module rbe_entry (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld,
	input  rbe_pkg::side_t          side,
	input  logic                    hit,
	input  logic                    enter,
	input  logic [rbe_pkg::T_W:0]   step,
	output logic                    done,
	output logic                    hit_q,
	output logic                    inside_q,
	output rbe_pkg::pos_t [2:0]     res_q
);
	import rbe_pkg::*;

	logic [TH_W-1:0]     th;
	logic [DIR_FRAC-1:0] tl;

	logic signed [PH_W-1:0] ph_s1 [3];
	logic signed [PL_W-1:0] pl_s1 [3];
	pos_t [2:0]             pos_s1;
	logic                   vld_s1;
	logic                   hit_s1;
	logic                   inside_s1;
	logic                   enter_s1;

	pos_t [2:0]             res_c;

	assign th = step[T_W:DIR_FRAC];
	assign tl = step[DIR_FRAC-1:0];

	// Split product: whole and fractional parts of the distance.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ph_s1[i] <= $signed({1'b0, th}) * side.dir[i];
			pl_s1[i] <= $signed({1'b0, tl}) * side.dir[i];
		end
		pos_s1    <= side.pos;
		hit_s1    <= hit;
		inside_s1 <= side.in_box;
		enter_s1  <= enter;
	end

	// Sum with floor rounding, then saturate to the position range.
	always_comb begin
		logic signed [SUM_W-1:0] v;
		v = '0;
		for (int i = 0; i < 3; i++) begin
			v = SUM_W'(pos_s1[i]) + SUM_W'(ph_s1[i]) + SUM_W'(pl_s1[i] >>> DIR_FRAC);
			if (!enter_s1) begin
				res_c[i] = pos_s1[i];
			end else if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
				res_c[i] = v[POS_W-1:0];
			end else if (v[SUM_W-1]) begin
				res_c[i] = {1'b1, {(POS_W-1){1'b0}}};
			end else begin
				res_c[i] = {1'b0, {(POS_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= vld;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		hit_q    <= hit_s1;
		inside_q <= inside_s1;
		res_q    <= res_c;
	end

endmodule

/* src/ray_box_entry_point.sv */
// ----------------------------------------------------------------------------
// ray_box_entry_point: ray entry into an axis-aligned box, slab method
// Accepts one ray per cycle and returns hit, inside flag and entry point.
// ----------------------------------------------------------------------------
// Pipeline: a start transfer reaches its done strobe through one front
//   stage, nine divider stages, two selection and two entry-point stages.
// Throughput: one ray per cycle; busy is always low, as the pipeline
//   never holds, and results are presented for a single cycle.
// Reset: arst_n clears the pipeline valid bits and the six box bounds.
module ray_box_entry_point (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rbe_pkg::pos_t                     pos_x,
	input  rbe_pkg::pos_t                     pos_y,
	input  rbe_pkg::pos_t                     pos_z,
	input  rbe_pkg::dir_t                     dir_x,
	input  rbe_pkg::dir_t                     dir_y,
	input  rbe_pkg::dir_t                     dir_z,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rbe_pkg::CFG_W-1:0]         cfg_index,
	input  rbe_pkg::pos_t                     cfg_data,
	output logic                              done,
	output logic                              hit,
	output logic                              was_inside,
	output rbe_pkg::pos_t                     out_x,
	output rbe_pkg::pos_t                     out_y,
	output rbe_pkg::pos_t                     out_z
);
	import rbe_pkg::*;

	pos_t [NUM_REGS-1:0] bound_q;

	logic          vld_s1;
	side_t         side_s1;
	num_t [5:0]    nmag_s1;
	mag_t [2:0]    dmag_s1;

	tq_t  [5:0]    quot;
	logic          vld_d_q  [DIV_STAGES];
	side_t         side_d_q [DIV_STAGES];

	logic          vld_s2;
	side_t         side_s2;
	logic          hit_s2;
	logic          enter_s2;
	logic [T_W:0]  step_s2;

	pos_t [2:0]    res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Bound registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_X_MIN: bound_q[REG_X_MIN] <= cfg_data;
				REG_X_MAX: bound_q[REG_X_MAX] <= cfg_data;
				REG_Y_MIN: bound_q[REG_Y_MIN] <= cfg_data;
				REG_Y_MAX: bound_q[REG_Y_MAX] <= cfg_data;
				REG_Z_MIN: bound_q[REG_Z_MIN] <= cfg_data;
				REG_Z_MAX: bound_q[REG_Z_MAX] <= cfg_data;
				default: ;
			endcase
		end
	end

	rbe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.pos     ({pos_z, pos_y, pos_x}),
		.dir     ({dir_z, dir_y, dir_x}),
		.bnd     (bound_q),
		.vld_s1  (vld_s1),
		.side_s1 (side_s1),
		.nmag_s1 (nmag_s1),
		.dmag_s1 (dmag_s1)
	);

	// Six slab distances in parallel dividers.
	for (genvar l = 0; l < 6; l++) begin : g_div
		rbe_div u_div (
			.clk  (clk),
			.num  (nmag_s1[l]),
			.dmag (dmag_s1[l/2]),
			.quot (quot[l])
		);
	end

	// Side-band delay line matching the divider depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				vld_d_q[k] <= 1'b0;
			end
		end else begin
			vld_d_q[0] <= vld_s1;
			for (int k = 1; k < DIV_STAGES; k++) begin
				vld_d_q[k] <= vld_d_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_d_q[0] <= side_s1;
		for (int k = 1; k < DIV_STAGES; k++) begin
			side_d_q[k] <= side_d_q[k-1];
		end
	end

	rbe_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vld_d_q[DIV_STAGES-1]),
		.side     (side_d_q[DIV_STAGES-1]),
		.quot     (quot),
		.vld_s2   (vld_s2),
		.side_s2  (side_s2),
		.hit_s2   (hit_s2),
		.enter_s2 (enter_s2),
		.step_s2  (step_s2)
	);

	rbe_entry u_entry (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vld_s2),
		.side     (side_s2),
		.hit      (hit_s2),
		.enter    (enter_s2),
		.step     (step_s2),
		.done     (done),
		.hit_q    (hit),
		.inside_q (was_inside),
		.res_q    (res_q)
	);

	assign out_x = res_q[0];
	assign out_y = res_q[1];
	assign out_z = res_q[2];

	// Every transfer produces its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LATENCY) done)
		else $error("result strobe missing after a start transfer");

	// An origin inside the box always counts as a hit.
	a_inside_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_inside |-> hit)
		else $error("inside reported without hit");

	// A miss or an inside origin returns the position unchanged.
	a_pass_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && (!hit || was_inside) |->
			out_x == $past(pos_x, LATENCY) && out_y == $past(pos_y, LATENCY) &&
			out_z == $past(pos_z, LATENCY))
		else $error("position altered without an entry");

endmodule
